// ===== rtl/brec_pkg.sv =====
// shared types, constants and the bank map function of the banked ram expansion controller
package brec_pkg;

   localparam int BANK_COUNT_DEFAULT    = 64;
   localparam int STREAK_LENGTH_DEFAULT = 255;
   localparam int BANK_BYTES            = 16384;
   localparam int OFFSET_W              = 14;
   localparam int BANK_NUM_W            = 6;

   localparam logic [15:0] ADDR_PBCTL   = 16'hD303;
   localparam logic [15:0] ADDR_PORTB   = 16'hD301;
   localparam logic [15:0] ADDR_MODESET = 16'hD1FE;
   localparam logic [15:0] WIN_LO       = 16'h4000;
   localparam logic [15:0] WIN_HI       = 16'h8000;

   localparam logic [7:0] PORTB_RESET  = 8'hFF;
   localparam logic [7:0] PBCTL_RESET  = 8'h00;
   localparam int         PBCTL_ENABLE = 2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [7:0] MODE_0 = 8'd0;
   localparam logic [7:0] MODE_1 = 8'd1;
   localparam logic [7:0] MODE_2 = 8'd2;
   localparam logic [7:0] MODE_3 = 8'd3;
   localparam logic [7:0] MODE_4 = 8'd4;
   localparam logic [7:0] MODE_5 = 8'd5;
   localparam logic [7:0] MODE_6 = 8'd6;
   localparam logic [7:0] MODE_7 = 8'd7;

   // top bit flags an unmapped pattern
   localparam logic [BANK_NUM_W:0] NO_BANK = 7'h40;

   typedef struct packed {
      logic [15:0] bus_address;
      logic        cmd;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       drive_bus;
      logic       claimed;
      logic       host_reset;
   } rsp_type;

   function automatic logic [BANK_NUM_W:0] pick_bank(input logic [7:0] mode,
                                                     input logic [7:0] p);
      logic                  off;
      logic [8:0]            sum;
      logic [BANK_NUM_W:0]   r;
      off = p[4];
      sum = '0;
      r   = NO_BANK;
      case (mode) inside
         MODE_0: begin
            r = off ? NO_BANK : {5'd0, p[3:2]};
         end
         MODE_1: begin
            sum = 9'(p & 8'h0c) + 9'((p & 8'h40) >> 2);
            r   = off ? NO_BANK : {1'b0, sum[7:2]};
         end
         MODE_2, MODE_3: begin
            sum = 9'(p & 8'h0c) + 9'((p & 8'h60) >> 1);
            r   = off ? NO_BANK : {1'b0, sum[7:2]};
         end
         MODE_4: begin
            sum = 9'(p & 8'h0c) + 9'((p & 8'hc0) >> 2);
            r   = ((p & 8'h30) == 8'h30) ? NO_BANK : {1'b0, sum[7:2]};
         end
         MODE_5: begin
            sum = 9'(p & 8'h0e) + 9'((p & 8'h60) >> 1);
            r   = off ? NO_BANK : {1'b0, sum[6:1]};
         end
         MODE_6: begin
            sum = 9'(p & 8'h0e) + 9'((p & 8'hc0) >> 2);
            r   = off ? NO_BANK : {1'b0, sum[6:1]};
         end
         MODE_7: begin
            sum = 9'(p & 8'h0e) + 9'((p & 8'he0) >> 1);
            r   = off ? NO_BANK : {1'b0, sum[6:1]};
         end
         default: begin
            r = NO_BANK;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/banked_ram_expansion_controller_top.sv =====
// banked ram expansion controller: port registers, mode switch and banked byte store
//
//   channel  | ports                                   | carries
//   ---------+-----------------------------------------+------------------------------
//   request  | req_valid, req_ready, req_data          | one host bus access per beat
//   response | rsp_valid, rsp_ready, rsp_data          | one result per request beat
//   csr      | csr_write_enable, csr_write_data        | power-on mode straps
//
// a store read waits in S_READ for the synchronous store read port; other beats go straight to the response register.
// after reset the store is swept to zero, one byte per cycle, all BANK_COUNT*16384 bytes,
// with req_ready low; csr writes are taken during the sweep.
// a result waits in the response register; a new beat is taken as that register drains.
module banked_ram_expansion_controller_top #(
   parameter int BANK_COUNT    = brec_pkg::BANK_COUNT_DEFAULT,
   parameter int STREAK_LENGTH = brec_pkg::STREAK_LENGTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brec_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brec_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_write_data
);

   localparam int DEPTH  = BANK_COUNT * brec_pkg::BANK_BYTES;
   localparam int BANK_W = $clog2(BANK_COUNT);
   localparam int ADDR_W = BANK_W + brec_pkg::OFFSET_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [brec_pkg::BANK_NUM_W:0] BANK_LIMIT =
      (brec_pkg::BANK_NUM_W + 1)'(BANK_COUNT);
   localparam logic [7:0] STREAK_INIT = 8'(STREAK_LENGTH);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_READ  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        port_b_ff, port_b_in;
   logic [7:0]        port_ctl_ff, port_ctl_in;
   logic [7:0]        mode_ff, mode_in;
   logic [7:0]        streak_ff, streak_in;
   logic              rsp_valid_ff, rsp_valid_in;
   brec_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]        store_mem [DEPTH];
   logic [7:0]        mem_rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, item_addr;
   logic [7:0]        mem_wdata;

   logic                          accept, out_free, in_window, win_hit;
   logic [brec_pkg::BANK_NUM_W:0] bank;
   logic [7:0]                    streak_dec;
   brec_pkg::rsp_type             item_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign in_window = (req_data.bus_address >= brec_pkg::WIN_LO) &&
                      (req_data.bus_address <  brec_pkg::WIN_HI) &&
                      port_ctl_ff[brec_pkg::PBCTL_ENABLE];
   assign bank      = brec_pkg::pick_bank(mode_ff, port_b_ff);
   assign win_hit   = in_window && (bank < BANK_LIMIT);
   assign item_addr = {bank[BANK_W-1:0], req_data.bus_address[brec_pkg::OFFSET_W-1:0]};
   assign streak_dec = streak_ff - 8'd1;

   always_comb begin
      port_b_in   = port_b_ff;
      port_ctl_in = port_ctl_ff;
      mode_in     = mode_ff;
      streak_in   = streak_ff;
      item_rsp    = '0;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = item_addr;
      mem_wdata   = req_data.write_data;

      if (accept) begin
         if (req_data.bus_address == brec_pkg::ADDR_PBCTL) begin
            item_rsp.claimed = 1'b1;
            if (req_data.cmd == brec_pkg::CMD_READ) begin
               item_rsp.read_data = port_ctl_ff;
               item_rsp.drive_bus = 1'b1;
            end else begin
               port_ctl_in = req_data.write_data;
            end
         end else if (req_data.bus_address == brec_pkg::ADDR_PORTB) begin
            item_rsp.claimed = 1'b1;
            if (req_data.cmd == brec_pkg::CMD_READ) begin
               item_rsp.read_data = port_b_ff;
               item_rsp.drive_bus = 1'b1;
            end else if (port_ctl_ff[brec_pkg::PBCTL_ENABLE]) begin
               port_b_in = req_data.write_data;
            end
         end else if (req_data.bus_address == brec_pkg::ADDR_MODESET) begin
            if (req_data.cmd == brec_pkg::CMD_READ) begin
               streak_in = STREAK_INIT;
            end else if (streak_dec == 8'd0) begin
               mode_in             = req_data.write_data;
               port_b_in           = brec_pkg::PORTB_RESET;
               port_ctl_in         = brec_pkg::PBCTL_RESET;
               streak_in           = STREAK_INIT;
               item_rsp.host_reset = 1'b1;
            end else begin
               streak_in = streak_dec;
            end
         end else if (win_hit) begin
            item_rsp.claimed = 1'b1;
            if (req_data.cmd == brec_pkg::CMD_READ) begin
               mem_re = 1'b1;
            end else begin
               mem_we = 1'b1;
            end
         end
      end

      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end

      // the user writes straps only while idle, which the block does not enforce; they also reload the live mode
      if (csr_write_enable) begin
         mode_in = {5'd0, csr_write_data};
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (mem_re) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = item_rsp;
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_data   = mem_rdata_ff;
               rsp_in.drive_bus   = 1'b1;
               rsp_in.claimed     = 1'b1;
               rsp_in.host_reset  = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         port_b_ff    <= brec_pkg::PORTB_RESET;
         port_ctl_ff  <= brec_pkg::PBCTL_RESET;
         mode_ff      <= '0;
         streak_ff    <= STREAK_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         port_b_ff    <= port_b_in;
         port_ctl_ff  <= port_ctl_in;
         mode_ff      <= mode_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // a beat reads or writes, never both, and a later beat sees an earlier write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= store_mem[item_addr];
      end
   end

   a_no_beat_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during store clear");

   a_drive_needs_claim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_bus) |-> rsp_data.claimed)
      else $error("bus driven on unclaimed access");

   a_quiet_when_not_driving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.drive_bus) |-> (rsp_data.read_data == 8'd0))
      else $error("read data nonzero without drive");

   a_reset_pulse_unclaimed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.host_reset) |-> !rsp_data.claimed)
      else $error("host reset on claimed access");

   a_store_read_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && mem_re) |=> (state_ff == S_READ))
      else $error("store read lost its completion cycle");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the banked ram expansion controller top level
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES = brec_pkg::BANK_COUNT_DEFAULT * brec_pkg::BANK_BYTES;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   brec_pkg::req_type req_data         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b1;
   brec_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [2:0]        csr_write_data   = '0;

   // shadow copy of the block state
   bit [7:0]   shadow_ram [STORE_BYTES];
   logic [7:0] port_b_shadow = brec_pkg::PORTB_RESET;
   logic [7:0] port_ctl_shadow = brec_pkg::PBCTL_RESET;
   logic [7:0] mode_shadow = brec_pkg::MODE_0;
   int         streak_left = brec_pkg::STREAK_LENGTH_DEFAULT;

   brec_pkg::rsp_type due_results [$];

   int fail_count = 0;
   int beats_sent = 0;
   int results_checked = 0;
   int claimed_count = 0;
   int host_resets = 0;
   int strap_writes = 0;
   int req_steady = 0;
   int rsp_steady = 0;
   int rsp_hold = 0;

   banked_ram_expansion_controller_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // bank picked by the expansion mode from port b, -1 when unmapped
   function automatic int bank_for_port(input logic [7:0] mode, input logic [7:0] p);
      bit off;
      off = p[4];
      case (mode)
         brec_pkg::MODE_0:
            return off ? -1 : int'(p[3:2]);
         brec_pkg::MODE_1:
            return off ? -1 : (int'(p & 8'h0c) + (int'(p & 8'h40) >> 2)) >> 2;
         brec_pkg::MODE_2, brec_pkg::MODE_3:
            return off ? -1 : (int'(p & 8'h0c) + (int'(p & 8'h60) >> 1)) >> 2;
         brec_pkg::MODE_4:
            return ((p & 8'h30) == 8'h30) ? -1
                   : (int'(p & 8'h0c) + (int'(p & 8'hc0) >> 2)) >> 2;
         brec_pkg::MODE_5:
            return off ? -1 : (int'(p & 8'h0e) + (int'(p & 8'h60) >> 1)) >> 1;
         brec_pkg::MODE_6:
            return off ? -1 : (int'(p & 8'h0e) + (int'(p & 8'hc0) >> 2)) >> 1;
         brec_pkg::MODE_7:
            return off ? -1 : (int'(p & 8'h0e) + (int'(p & 8'he0) >> 1)) >> 1;
         default: return -1;
      endcase
   endfunction

   // updates the shadow state for one bus access and returns its result
   function automatic brec_pkg::rsp_type apply_access(input brec_pkg::req_type a);
      brec_pkg::rsp_type r;
      int                bank;
      int                idx;
      r = '0;
      if (a.bus_address == brec_pkg::ADDR_PBCTL) begin
         r.claimed = 1'b1;
         if (a.cmd == brec_pkg::CMD_READ) begin
            r.read_data = port_ctl_shadow;
            r.drive_bus = 1'b1;
         end else begin
            port_ctl_shadow = a.write_data;
         end
      end else if (a.bus_address == brec_pkg::ADDR_PORTB) begin
         r.claimed = 1'b1;
         if (a.cmd == brec_pkg::CMD_READ) begin
            r.read_data = port_b_shadow;
            r.drive_bus = 1'b1;
         end else if (port_ctl_shadow[brec_pkg::PBCTL_ENABLE]) begin
            port_b_shadow = a.write_data;
         end
      end else if (a.bus_address == brec_pkg::ADDR_MODESET) begin
         if (a.cmd == brec_pkg::CMD_READ) begin
            streak_left = brec_pkg::STREAK_LENGTH_DEFAULT;
         end else begin
            streak_left--;
            if (streak_left == 0) begin
               mode_shadow     = a.write_data;
               port_b_shadow   = brec_pkg::PORTB_RESET;
               port_ctl_shadow = brec_pkg::PBCTL_RESET;
               streak_left     = brec_pkg::STREAK_LENGTH_DEFAULT;
               r.host_reset    = 1'b1;
               host_resets++;
            end
         end
      end else if (a.bus_address >= brec_pkg::WIN_LO && a.bus_address < brec_pkg::WIN_HI &&
                   port_ctl_shadow[brec_pkg::PBCTL_ENABLE]) begin
         bank = bank_for_port(mode_shadow, port_b_shadow);
         if (bank >= 0 && bank < brec_pkg::BANK_COUNT_DEFAULT) begin
            r.claimed = 1'b1;
            idx = bank * brec_pkg::BANK_BYTES + int'(a.bus_address - brec_pkg::WIN_LO);
            if (a.cmd == brec_pkg::CMD_READ) begin
               r.read_data = shadow_ram[idx];
               r.drive_bus = 1'b1;
            end else begin
               shadow_ram[idx] = a.write_data;
            end
         end
      end
      if (r.claimed) claimed_count++;
      return r;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int idle_len(ref int steady);
      int r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) steady = $urandom_range(80, 20);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(50, 20);
   endfunction

   function automatic brec_pkg::req_type pick_random_access(input bit allow_modeset);
      brec_pkg::req_type a;
      int                sel;
      a.cmd        = 1'($urandom_range(1));
      a.write_data = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 40) begin
         // revisit a handful of offsets so reads hit earlier writes
         case ($urandom_range(4))
            0: a.bus_address = brec_pkg::WIN_LO;
            1: a.bus_address = brec_pkg::WIN_HI - 16'd1;
            2: a.bus_address = brec_pkg::WIN_LO + 16'($urandom_range(7));
            3: a.bus_address = brec_pkg::WIN_LO + 16'h2000 + 16'($urandom_range(7));
            default: a.bus_address = brec_pkg::WIN_LO + 16'($urandom_range(16'h3FFF));
         endcase
      end else if (sel < 52) begin
         a.bus_address = brec_pkg::ADDR_PORTB;
         if ($urandom_range(3) != 0) a.write_data[4] = 1'b0;
      end else if (sel < 60) begin
         a.bus_address = brec_pkg::ADDR_PBCTL;
         if ($urandom_range(4) != 0) a.write_data[brec_pkg::PBCTL_ENABLE] = 1'b1;
      end else if (sel < 68 && allow_modeset) begin
         a.bus_address = brec_pkg::ADDR_MODESET;
         a.cmd = ($urandom_range(9) == 0) ? brec_pkg::CMD_READ : brec_pkg::CMD_WRITE;
      end else begin
         a.bus_address = 16'($urandom);
         if (!allow_modeset && a.bus_address == brec_pkg::ADDR_MODESET) begin
            a.bus_address[0] = 1'b1;
         end
      end
      return a;
   endfunction

   task automatic send_access(input brec_pkg::req_type item);
      int gap;
      gap = idle_len(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      due_results.push_back(apply_access(item));
   endtask

   task automatic bus_access(input logic [15:0] addr, input logic cmd,
                             input logic [7:0] data);
      brec_pkg::req_type a;
      a.bus_address = addr;
      a.cmd         = cmd;
      a.write_data  = data;
      send_access(a);
   endtask

   task automatic random_traffic(input int count);
      repeat (count) send_access(pick_random_access(1'b1));
   endtask

   // strap write only once every result is back
   task automatic write_straps(input logic [2:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mode_shadow = 8'(value);
      strap_writes++;
   endtask

   // completes the write streak with new_mode as the last byte, other traffic mixed in
   task automatic run_mode_switch(input logic [7:0] new_mode, input int mix_pct);
      int left;
      left = streak_left;
      for (int k = 0; k < left; k++) begin
         if ($urandom_range(99) < mix_pct) send_access(pick_random_access(1'b0));
         bus_access(brec_pkg::ADDR_MODESET, brec_pkg::CMD_WRITE,
                    (k == left - 1) ? new_mode : 8'($urandom));
      end
   endtask

   task automatic test_directed();
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_READ, 8'hFF);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h00);  // ignored, bit 2 clear
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);       // window disabled
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'hFF);
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h00);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_WRITE, 8'hFF);
      bus_access(brec_pkg::WIN_HI - 16'd1, brec_pkg::CMD_WRITE, 8'h5A);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::WIN_HI - 16'd1, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::WIN_LO - 16'd1, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::WIN_HI, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h0C);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h10);  // bit 4 unmaps the bank
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);
      bus_access(16'h0000, brec_pkg::CMD_WRITE, 8'hFF);
      bus_access(16'hFFFF, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_MODESET, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_MODESET, brec_pkg::CMD_WRITE, 8'h00);
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'h00);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'h04);
   endtask

   task automatic test_mode_switch();
      // unknown mode: ports reset, window never claimed
      run_mode_switch(8'h80, 10);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_READ, 8'h00);
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'h04);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h00);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);
      // a read of the mode register breaks a partial streak
      repeat (120) bus_access(brec_pkg::ADDR_MODESET, brec_pkg::CMD_WRITE, 8'($urandom));
      bus_access(brec_pkg::ADDR_MODESET, brec_pkg::CMD_READ, 8'h00);
      run_mode_switch(brec_pkg::MODE_7, 15);
      // store contents survive the switch
      bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'h04);
      bus_access(brec_pkg::ADDR_PORTB, brec_pkg::CMD_WRITE, 8'h00);
      bus_access(brec_pkg::WIN_LO, brec_pkg::CMD_READ, 8'h00);
   endtask

   task automatic test_strap_modes();
      logic [2:0] straps [8] = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4};
      foreach (straps[i]) begin
         write_straps(straps[i]);
         bus_access(brec_pkg::ADDR_PBCTL, brec_pkg::CMD_WRITE, 8'h04);
         random_traffic(160);
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = idle_len(rsp_steady);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin : check_beat
         brec_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            $error("result beat with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            results_checked++;
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data expected %02h got %02h", want.read_data, rsp_data.read_data);
               fail_count++;
            end
            if (rsp_data.drive_bus !== want.drive_bus) begin
               $error("drive_bus expected %0b got %0b", want.drive_bus, rsp_data.drive_bus);
               fail_count++;
            end
            if (rsp_data.claimed !== want.claimed) begin
               $error("claimed expected %0b got %0b", want.claimed, rsp_data.claimed);
               fail_count++;
            end
            if (rsp_data.host_reset !== want.host_reset) begin
               $error("host_reset expected %0b got %0b", want.host_reset, rsp_data.host_reset);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_mode_switch();
      test_strap_modes();
      @(negedge clock);
      req_valid = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("ran %0d bus accesses, %0d results checked, %0d of them claimed",
               beats_sent, results_checked, claimed_count);
      $display("saw %0d mode switches by write streak and %0d strap settings",
               host_resets, strap_writes);
      if (fail_count == 0) begin
         $display("PASS banked_ram_expansion_controller_top");
      end else begin
         $display("FAIL banked_ram_expansion_controller_top");
      end
      $finish;
   end

   // the timeout covers the store sweep after reset, the rest is margin
   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", due_results.size());
      $display("FAIL banked_ram_expansion_controller_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/brec_pkg.sv
rtl/banked_ram_expansion_controller_top.sv
tb/sv/tb_top.sv
